// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the square root block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while the block is out of reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property checked on every rising edge, during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/isqrt_pkg.sv -----
// Package of types and constants for the integer square root pipeline.
`default_nettype none

package isqrt_pkg;

  // Width of the radicand port and of the root port.
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;

  // Number of radicand bits the unit takes in (8 to 64).
  localparam int INPUT_WIDTH = 64;

  // One root bit is settled per stage.
  localparam int STEPS = 32;

  // Keeps only the low INPUT_WIDTH bits of the radicand.
  localparam logic [RAD_W-1:0] RAD_MASK =
    (INPUT_WIDTH >= RAD_W) ? {RAD_W{1'b1}}
                           : ((64'd1 << INPUT_WIDTH) - 64'd1);

  // Working state carried from stage to stage.
  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] acc;
  } work_t;

  // Trial bit of a stage: 4^(31 - stage).
  function automatic logic [RAD_W-1:0] probe_of(input int stage);
    logic [RAD_W-1:0] p;
    p = 64'd1 << (62 - 2 * stage);
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- src/integer_square_root.sv -----
// Integer square root: a beat of radicand in, a beat of floor(sqrt(radicand)) out.
//
// The slave side takes one 64-bit radicand per beat on s_tdata_i; only the
// low INPUT_WIDTH bits (a package constant) count. The master side returns
// the 32-bit floor of its square root on m_tdata_o, one beat per input beat,
// in order.
// The datapath is a chain of 32 registered stages, each settling one root
// bit with two 64-bit adds, a compare and a subtract. m_tvalid_o is the valid
// register of the last stage; throughput is one beat per cycle while the
// receiver does not stall.
// Each stage has its own valid bit and takes a beat whenever it is empty or
// its content moves on, so bubbles close up. When the receiver stalls, the
// last stage holds its result and the stages behind it keep filling; s_tready_o
// drops only when all 32 stages hold a beat. Nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; the payload registers
// are not reset, and the block has no configuration.
`default_nettype none

module integer_square_root (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [63:0] s_tdata_i,   // [63:0] radicand
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o    // [31:0] root
);

  localparam int N = isqrt_pkg::STEPS;

  logic             valid [N+1];
  logic             ready [N+1];
  isqrt_pkg::work_t work  [N+1];

  // Entry of the chain: masked radicand, empty root accumulator.
  assign valid[0]     = s_tvalid_i;
  assign s_tready_o   = ready[0];
  assign work[0].rem  = s_tdata_i & isqrt_pkg::RAD_MASK;
  assign work[0].acc  = '0;

  // One stage per root bit, most significant bit first.
  for (genvar g = 0; g < N; g++) begin : g_stage
    isqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (isqrt_pkg::probe_of(g)),
      .valid_i (valid[g]),
      .ready_o (ready[g]),
      .work_i  (work[g]),
      .valid_o (valid[g+1]),
      .ready_i (ready[g+1]),
      .work_o  (work[g+1])
    );
  end

  // Exit of the chain.
  assign ready[N]   = m_tready_i;
  assign m_tvalid_o = valid[N];
  assign m_tdata_o  = work[N].acc[isqrt_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- src/isqrt_stage.sv -----
// One pipeline stage of the digit-by-digit square root: settles one root bit.
`default_nettype none

module isqrt_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [isqrt_pkg::RAD_W-1:0]  probe_i,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire isqrt_pkg::work_t             work_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output isqrt_pkg::work_t                  work_o
);

  logic                        valid_q;
  isqrt_pkg::work_t            work_q;
  isqrt_pkg::work_t            work_d;
  logic [isqrt_pkg::RAD_W-1:0] trial;

  // Subtract the trial value when it fits and set the new root bit.
  always_comb begin
    trial = work_i.acc + probe_i;
    if (work_i.rem >= trial) begin
      work_d.rem = work_i.rem - trial;
      work_d.acc = (work_i.acc >> 1) + probe_i;
    end else begin
      work_d.rem = work_i.rem;
      work_d.acc = work_i.acc >> 1;
    end
  end

  // The stage takes a new beat when it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload register, loaded only with a live beat.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

// ----- src/isqrt_chk.sv -----
// Port checker for the integer square root block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module isqrt_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid_i,
  input wire logic        s_tready_o,
  input wire logic [63:0] s_tdata_i,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [31:0] m_tdata_o
);

  // A result beat that is not taken stays put.
  `ASSERT_ON(a_out_hold, m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o), "result beat changed while stalled")

  // No result is offered after reset is sampled active.
  `ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !m_tvalid_o, "result valid during reset")

  // The input side only backs up when the whole pipeline is full and blocked.
  `ASSERT_ON(a_stall_cause, !s_tready_o |-> m_tvalid_o && !m_tready_i, "input stalled without output stall")

  // While the receiver takes beats, every stage can move on, so the input
  // side is ready.
  `ASSERT_ON(a_ready_free, m_tready_i |-> s_tready_o, "input not ready while output ready")

endmodule

bind integer_square_root isqrt_chk u_isqrt_chk (.*);

`default_nettype wire
